// File: src/assert_macros.svh
// assertion macros for the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising clock edge outside reset
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");

// implication whose consequent is checked in the cycle after the antecedent
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`endif

// File: src/soa_pkg.sv
// package for the slab object allocator: sizes, codes and state types
// no dependencies
`default_nettype none
package soa_pkg;
    localparam int MaxSlabs   = 16;
    localparam int MaxObjects = 64;
    localparam int MinSlots   = 8;
    localparam int SlabW      = $clog2(MaxSlabs);
    localparam int ObjW       = $clog2(MaxObjects);
    localparam int SlabNilW   = SlabW + 1;
    localparam int CntW       = ObjW + 1;
    localparam int LinkAw     = SlabW + ObjW;
    localparam int OpslW      = 7;
    localparam int FavW       = 5;
    localparam logic [SlabNilW-1:0] Nil = SlabNilW'(MaxSlabs);

    typedef enum logic [1:0] {
        OP_ALLOC    = 2'd0,
        OP_FREE     = 2'd1,
        OP_FREE_ALL = 2'd2,
        OP_NONE     = 2'd3
    } t_op;

    localparam logic CFG_OBJECTS_PER_SLAB = 1'b0;
    localparam logic CFG_FRAMES_AVAILABLE = 1'b1;

    typedef struct packed {
        logic [ObjW-1:0]     head;
        logic [CntW-1:0]     count;
        logic [SlabNilW-1:0] next;
        logic [SlabNilW-1:0] prev;
    } t_slab;

    localparam int SlabRecW = $bits(t_slab);
endpackage
`default_nettype wire

// File: src/slab_object_allocator_top.sv
// slab object allocator top level: sequencer over the link and slab-record rams
// depends on soa_pkg and soa_ram
//
// usage: one request channel (operation, slab_index, object_index) and one
// result channel, both valid/stall. every request gives exactly one result.
// a request is taken only while no result waits and the sequencer is idle.
// after a request is taken: allocate from a partial slab reads the slab
// record, then the link entry at its head; a free without a list move
// reads the slab record and writes the link entry; free-all, an ignored
// free, a failed allocate or an unused operation go straight to finish.
// a move between slab lists unlinks the slab, updating a list head or each
// neighbor slab record by read-modify-write, then, unless the slab is
// released, pushes it onto the target list and updates the old head's
// record. claiming a frame first writes one link entry per effective slot
// (8 to 64). the next request can be taken in the cycle after the result
// transfer. the link ram and slab-record ram have one write and one
// registered read each. reset empties both slab lists and marks every
// frame unused; other ram contents are undefined until written. a stalled
// result holds and no new request is taken; configuration writes apply at once.
`default_nettype none
module slab_object_allocator_top (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [1:0] i_operation,
    input  wire logic [3:0] i_slab_index,
    input  wire logic [5:0] i_object_index,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic            o_status,
    output logic [3:0]      o_alloc_slab,
    output logic [5:0]      o_alloc_object,
    output logic            o_slab_claimed,
    output logic            o_slab_released,
    input  wire logic       i_cfg_we,
    input  wire logic [0:0] i_cfg_index,
    input  wire logic [6:0] i_cfg_data
);
    localparam int SW = soa_pkg::SlabW;
    localparam int OW = soa_pkg::ObjW;
    localparam int NW = soa_pkg::SlabNilW;
    localparam int CW = soa_pkg::CntW;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_CLAIM = 10'b0000000010,
        S_RD    = 10'b0000000100,
        S_DEC   = 10'b0000001000,
        S_LNK   = 10'b0000010000,
        S_NBR   = 10'b0000100000,
        S_NBRW  = 10'b0001000000,
        S_PUSH  = 10'b0010000000,
        S_PUSHW = 10'b0100000000,
        S_FIN   = 10'b1000000000
    } t_state;

    t_state r_state, n_state;

    logic [soa_pkg::OpslW-1:0] r_opsl;
    logic [soa_pkg::FavW-1:0]  r_fav;
    logic [soa_pkg::MaxSlabs-1:0] r_inuse, n_inuse;
    logic [NW-1:0] r_phead, n_phead, r_fhead, n_fhead;

    logic [1:0]    r_op, n_op;
    logic [SW-1:0] r_slab, n_slab;
    logic [OW-1:0] r_obj, n_obj;
    logic [CW-1:0] r_idx, n_idx;
    logic          r_dirty, n_dirty;
    soa_pkg::t_slab r_rec, n_rec;
    // list-move steps: unlink from (prev,next), then, unless released, push onto target list
    logic          r_to_full, n_to_full;
    logic          r_release, n_release;
    logic          r_unl_done, n_unl_done;
    logic          r_nbr_is_prev, n_nbr_is_prev;
    logic [SW-1:0] r_nbr, n_nbr;

    logic          r_ovalid, n_ovalid;
    logic          r_status, n_status, r_claimed, n_claimed, r_released, n_released;
    logic [SW-1:0] r_aslab, n_aslab;
    logic [OW-1:0] r_aobj, n_aobj;

    logic [CW-1:0] slots;
    logic [NW-1:0] limit;
    logic [NW-1:0] free_f;
    logic          found;

    logic                       lk_we;
    logic [soa_pkg::LinkAw-1:0] lk_wa, lk_ra;
    logic [OW-1:0]              lk_wd, lk_rd;
    logic                       sr_we;
    logic [SW-1:0]              sr_wa, sr_ra;
    soa_pkg::t_slab             sr_wd, sr_rd;

    soa_ram #(.Width(OW), .Depth(soa_pkg::MaxSlabs * soa_pkg::MaxObjects)) u_link (
        .i_clk(i_clk), .i_we(lk_we), .i_waddr(lk_wa), .i_wdata(lk_wd),
        .i_raddr(lk_ra), .o_rdata(lk_rd)
    );
    soa_ram #(.Width(soa_pkg::SlabRecW), .Depth(soa_pkg::MaxSlabs)) u_slab (
        .i_clk(i_clk), .i_we(sr_we), .i_waddr(sr_wa), .i_wdata(sr_wd),
        .i_raddr(sr_ra), .o_rdata(sr_rd)
    );

    always_comb begin
        if (r_opsl < CW'(soa_pkg::MinSlots)) begin
            slots = CW'(soa_pkg::MinSlots);
        end else if (r_opsl > CW'(soa_pkg::MaxObjects)) begin
            slots = CW'(soa_pkg::MaxObjects);
        end else begin
            slots = CW'(r_opsl);
        end
        limit = (r_fav > NW'(soa_pkg::MaxSlabs)) ? soa_pkg::Nil : NW'(r_fav);
        free_f = soa_pkg::Nil;
        found  = 1'b0;
        for (int f = soa_pkg::MaxSlabs - 1; f >= 0; f--) begin
            if (!r_inuse[f] && NW'(f) < limit) begin
                free_f = NW'(f);
                found  = 1'b1;
            end
        end
    end

    assign o_stall         = (r_state != S_IDLE) || r_ovalid;
    assign o_valid         = r_ovalid;
    assign o_status        = r_status;
    assign o_alloc_slab    = r_aslab;
    assign o_alloc_object  = r_aobj;
    assign o_slab_claimed  = r_claimed;
    assign o_slab_released = r_released;

    always_comb begin
        n_state = r_state;  n_inuse = r_inuse;  n_phead = r_phead;  n_fhead = r_fhead;
        n_op = r_op;  n_slab = r_slab;  n_obj = r_obj;  n_idx = r_idx;  n_dirty = r_dirty;
        n_rec = r_rec;  n_to_full = r_to_full;  n_release = r_release;
        n_unl_done = r_unl_done;  n_nbr_is_prev = r_nbr_is_prev;  n_nbr = r_nbr;
        n_ovalid = r_ovalid && i_stall;
        n_status = r_status;  n_claimed = r_claimed;  n_released = r_released;
        n_aslab = r_aslab;  n_aobj = r_aobj;
        lk_we = 1'b0;  lk_wa = {r_slab, r_obj};  lk_wd = r_obj;  lk_ra = {r_slab, r_obj};
        sr_we = 1'b0;  sr_wa = r_slab;  sr_wd = r_rec;  sr_ra = r_slab;

        case (r_state)
            S_IDLE: begin
                if (i_valid && !o_stall) begin
                    n_op = i_operation;  n_slab = i_slab_index;  n_obj = i_object_index;
                    n_status = 1'b0;  n_claimed = 1'b0;  n_released = 1'b0;
                    n_aslab = '0;  n_aobj = '0;
                    n_unl_done = 1'b0;  n_release = 1'b0;
                    sr_ra = i_slab_index;
                    case (soa_pkg::t_op'(i_operation))
                        soa_pkg::OP_ALLOC: begin
                            if (r_phead != soa_pkg::Nil) begin
                                n_slab = r_phead[SW-1:0];
                                sr_ra  = r_phead[SW-1:0];
                                n_state = S_RD;
                            end else if (found) begin
                                n_slab = free_f[SW-1:0];
                                n_claimed = 1'b1;
                                n_idx = '0;
                                n_state = S_CLAIM;
                            end else begin
                                n_status = 1'b1;
                                n_state = S_FIN;
                            end
                        end
                        soa_pkg::OP_FREE: begin
                            if (r_inuse[i_slab_index] && CW'(i_object_index) < slots) begin
                                n_state = S_RD;
                            end else begin
                                n_state = S_FIN;
                            end
                        end
                        soa_pkg::OP_FREE_ALL: begin
                            n_inuse = '0;  n_phead = soa_pkg::Nil;  n_fhead = soa_pkg::Nil;
                            n_state = S_FIN;
                        end
                        default: n_state = S_FIN;
                    endcase
                end
            end
            S_CLAIM: begin
                // each slot links to the one below, slot 0 to itself
                lk_we = 1'b1;
                lk_wa = {r_slab, r_idx[OW-1:0]};
                lk_wd = (r_idx == '0) ? '0 : OW'(r_idx - CW'(1));
                if (r_idx == slots - CW'(1)) begin
                    n_inuse[r_slab] = 1'b1;
                    sr_we = 1'b1;
                    sr_wd.head  = OW'(slots - CW'(1));
                    sr_wd.count = slots;
                    sr_wd.prev  = soa_pkg::Nil;
                    sr_wd.next  = r_phead;
                    n_phead = {1'b0, r_slab};
                    sr_ra = r_slab;
                    n_state = S_RD;
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end
            S_RD: begin
                // slab record now readable next cycle
                n_state = S_DEC;
                sr_ra = r_slab;
            end
            S_DEC: begin
                n_rec = sr_rd;
                if (r_op == soa_pkg::OP_ALLOC) begin
                    n_aslab = r_slab;
                    n_aobj  = sr_rd.head;
                    lk_ra   = {r_slab, sr_rd.head};
                    n_state = S_LNK;
                end else begin
                    lk_we = 1'b1;
                    lk_wa = {r_slab, r_obj};
                    lk_wd = sr_rd.head;
                    n_rec.head  = r_obj;
                    n_rec.count = sr_rd.count + CW'(1);
                    n_to_full = 1'b0;
                    if (sr_rd.count + CW'(1) >= slots) begin
                        n_release = 1'b1;
                        n_released = 1'b1;
                        n_inuse[r_slab] = 1'b0;
                        n_state = S_NBR;
                    end else if (sr_rd.count == '0) begin
                        n_state = S_NBR;
                    end else begin
                        n_state = S_FIN;
                        n_dirty = 1'b1;
                    end
                end
            end
            S_LNK: begin
                n_rec.head = lk_rd;
                if (r_rec.count != '0) begin
                    n_rec.count = r_rec.count - CW'(1);
                end
                if (r_rec.count <= CW'(1)) begin
                    n_to_full = 1'b1;
                    n_state = S_NBR;
                end else begin
                    n_dirty = 1'b1;
                    n_state = S_FIN;
                end
            end
            S_NBR: begin
                // unlink: fix prev neighbor or head, then next neighbor
                if (!r_unl_done) begin
                    n_unl_done = 1'b1;
                    if (r_rec.prev != soa_pkg::Nil) begin
                        n_nbr = r_rec.prev[SW-1:0];
                        n_nbr_is_prev = 1'b1;
                        sr_ra = r_rec.prev[SW-1:0];
                        n_state = S_NBRW;
                    end else if (r_phead == {1'b0, r_slab}) begin
                        n_phead = r_rec.next;
                    end else begin
                        n_fhead = r_rec.next;
                    end
                end else if (r_rec.next != soa_pkg::Nil) begin
                    n_nbr = r_rec.next[SW-1:0];
                    n_nbr_is_prev = 1'b0;
                    sr_ra = r_rec.next[SW-1:0];
                    n_state = S_NBRW;
                end else begin
                    n_state = r_release ? S_FIN : S_PUSH;
                end
            end
            S_NBRW: begin
                // wait for the read while r_idx bit 0 is clear, then write
                if (r_idx[0] == 1'b0) begin
                    n_idx = CW'(1);
                end else begin
                    n_idx = '0;
                    sr_we = 1'b1;
                    sr_wa = r_nbr;
                    sr_wd = sr_rd;
                    if (r_nbr_is_prev) begin
                        sr_wd.next = r_rec.next;
                        n_state = S_NBR;
                    end else begin
                        sr_wd.prev = r_rec.prev;
                        n_state = r_release ? S_FIN : S_PUSH;
                    end
                end
                sr_ra = r_nbr;
            end
            S_PUSH: begin
                n_rec.prev = soa_pkg::Nil;
                n_rec.next = r_to_full ? r_fhead : r_phead;
                if (r_to_full) begin
                    n_fhead = {1'b0, r_slab};
                end else begin
                    n_phead = {1'b0, r_slab};
                end
                n_dirty = 1'b1;
                n_idx = '0;
                if ((r_to_full ? r_fhead : r_phead) != soa_pkg::Nil) begin
                    n_nbr = (r_to_full ? r_fhead[SW-1:0] : r_phead[SW-1:0]);
                    sr_ra = (r_to_full ? r_fhead[SW-1:0] : r_phead[SW-1:0]);
                    n_state = S_PUSHW;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_PUSHW: begin
                sr_ra = r_nbr;
                if (r_idx[0] == 1'b0) begin
                    n_idx = CW'(1);
                end else begin
                    n_idx = '0;
                    sr_we = 1'b1;
                    sr_wa = r_nbr;
                    sr_wd = sr_rd;
                    sr_wd.prev = {1'b0, r_slab};
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (r_dirty) begin
                    sr_we = 1'b1;
                    sr_wa = r_slab;
                    sr_wd = r_rec;
                end
                n_dirty = 1'b0;
                n_ovalid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_inuse <= '0;
            r_phead <= soa_pkg::Nil;
            r_fhead <= soa_pkg::Nil;
            r_ovalid <= 1'b0;
            r_dirty <= 1'b0;
            r_opsl <= soa_pkg::OpslW'(soa_pkg::MaxObjects);
            r_fav <= soa_pkg::FavW'(soa_pkg::MaxSlabs);
            r_idx <= '0;
            r_unl_done <= 1'b0;
            r_nbr_is_prev <= 1'b0;
        end else begin
            r_state <= n_state;
            r_inuse <= n_inuse;
            r_phead <= n_phead;
            r_fhead <= n_fhead;
            r_ovalid <= n_ovalid;
            r_dirty <= n_dirty;
            r_idx <= n_idx;
            r_unl_done <= n_unl_done;
            r_nbr_is_prev <= n_nbr_is_prev;
            if (i_cfg_we) begin
                if (i_cfg_index == soa_pkg::CFG_OBJECTS_PER_SLAB) begin
                    r_opsl <= i_cfg_data;
                end else begin
                    r_fav <= i_cfg_data[soa_pkg::FavW-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op;  r_slab <= n_slab;  r_obj <= n_obj;  r_rec <= n_rec;
        r_to_full <= n_to_full;  r_release <= n_release;  r_nbr <= n_nbr;
        r_status <= n_status;  r_claimed <= n_claimed;  r_released <= n_released;
        r_aslab <= n_aslab;  r_aobj <= n_aobj;
    end
endmodule
`default_nettype wire

// File: src/soa_ram.sv
// generic single-port-write, one-read ram with registered read
// no dependencies
`default_nettype none
module soa_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: src/soa_checker.sv
// port-level checker for the slab object allocator, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"
`default_nettype none
module soa_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_stall,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic       o_status,
    input wire logic       o_slab_claimed,
    input wire logic       o_slab_released
);
    `CHK_IMPL(a_fail_not_claim, i_clk, i_rst_n, o_valid && o_status, !o_slab_claimed)
    `CHK_IMPL(a_claim_not_rel, i_clk, i_rst_n, o_valid && o_slab_claimed, !o_slab_released)
    `CHK_IMPL(a_no_take_while_out, i_clk, i_rst_n, o_valid, o_stall)
    `CHK_NEXT(a_out_holds, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_status))
    `CHK_NEXT(a_busy_after_take, i_clk, i_rst_n, i_valid && !o_stall, o_stall)
endmodule

bind slab_object_allocator_top soa_checker u_soa_checker (.*);
`default_nettype wire

// File: test/slab_object_allocator_top_test.sv
// self-checking testbench for slab_object_allocator_top: a behavioral slab list model
// predicts every result; traffic is directed cases, then random phases, with random stalls
// depends on soa_pkg and slab_object_allocator_top
`timescale 1ns / 1ps
`default_nettype none
module slab_object_allocator_top_test;
    typedef struct {
        bit       status;
        bit [3:0] slab;
        bit [5:0] obj;
        bit       claimed;
        bit       released;
    } t_outcome;

    typedef struct {
        int slab;
        int obj;
    } t_handle;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [1:0] i_operation = '0;
    logic [3:0] i_slab_index = '0;
    logic [5:0] i_object_index = '0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic       o_status;
    logic [3:0] o_alloc_slab;
    logic [5:0] o_alloc_object;
    logic       o_slab_claimed;
    logic       o_slab_released;
    logic       i_cfg_we = 1'b0;
    logic [0:0] i_cfg_index = '0;
    logic [6:0] i_cfg_data = '0;

    slab_object_allocator_top i_dut (.*);

    always #1 i_clk = ~i_clk;

    // shadow allocator state
    bit [5:0] obj_next [soa_pkg::MaxSlabs][soa_pkg::MaxObjects];
    int       slot_head [soa_pkg::MaxSlabs];
    int       slot_free [soa_pkg::MaxSlabs];
    bit       frame_busy [soa_pkg::MaxSlabs];
    int       slab_next [soa_pkg::MaxSlabs];
    int       slab_prev [soa_pkg::MaxSlabs];
    int       partial_top;
    int       full_top;
    int       slots_cfg;
    int       frames_cfg;

    t_outcome pending_results[$];
    t_handle  live_objects[$];
    int       errors;
    int       items_sent;
    int       results_seen;
    int       allocs_failed;
    int       frames_released;
    int       idle_cycles;
    int       burst_left;

    function automatic int eff_slots();
        if (slots_cfg < soa_pkg::MinSlots) return soa_pkg::MinSlots;
        if (slots_cfg > soa_pkg::MaxObjects) return soa_pkg::MaxObjects;
        return slots_cfg;
    endfunction

    function automatic void push_slab(int s, ref int top);
        slab_prev[s] = soa_pkg::MaxSlabs;
        slab_next[s] = top;
        if (top < soa_pkg::MaxSlabs) slab_prev[top] = s;
        top = s;
    endfunction

    function automatic void unlink_slab(int s, ref int top);
        int p;
        int n;
        p = slab_prev[s];
        n = slab_next[s];
        if (p < soa_pkg::MaxSlabs) slab_next[p] = n;
        else top = n;
        if (n < soa_pkg::MaxSlabs) slab_prev[n] = p;
    endfunction

    function automatic bit take_frame();
        int lim;
        int f;
        int n;
        lim = (frames_cfg > soa_pkg::MaxSlabs) ? soa_pkg::MaxSlabs : frames_cfg;
        for (f = 0; f < lim; f++)
            if (!frame_busy[f]) break;
        if (f >= lim) return 1'b0;
        n = eff_slots();
        for (int i = 1; i < n; i++) obj_next[f][i] = 6'(i - 1);
        obj_next[f][0] = '0;
        slot_head[f] = n - 1;
        slot_free[f] = n;
        frame_busy[f] = 1'b1;
        push_slab(f, partial_top);
        return 1'b1;
    endfunction

    function automatic t_outcome allocator_step(soa_pkg::t_op op, int sl, int ob);
        t_outcome r;
        int s;
        int o;
        r = '{default: 0};
        case (op)
            soa_pkg::OP_ALLOC: begin
                if (partial_top >= soa_pkg::MaxSlabs) begin
                    if (take_frame()) r.claimed = 1'b1;
                    else r.status = 1'b1;
                end
                if (!r.status && partial_top < soa_pkg::MaxSlabs) begin
                    s = partial_top;
                    o = slot_head[s] % soa_pkg::MaxObjects;
                    r.slab = 4'(s);
                    r.obj = 6'(o);
                    slot_head[s] = obj_next[s][o];
                    if (slot_free[s] > 0) slot_free[s]--;
                    if (slot_free[s] == 0) begin
                        unlink_slab(s, partial_top);
                        push_slab(s, full_top);
                    end
                end
            end
            soa_pkg::OP_FREE: begin
                if (frame_busy[sl] && ob < eff_slots()) begin
                    if (slot_free[sl] == 0) begin
                        unlink_slab(sl, full_top);
                        push_slab(sl, partial_top);
                    end
                    obj_next[sl][ob] = 6'(slot_head[sl]);
                    slot_head[sl] = ob;
                    slot_free[sl]++;
                    if (slot_free[sl] >= eff_slots()) begin
                        unlink_slab(sl, partial_top);
                        frame_busy[sl] = 1'b0;
                        r.released = 1'b1;
                    end
                end
            end
            soa_pkg::OP_FREE_ALL: begin
                for (int f = 0; f < soa_pkg::MaxSlabs; f++) frame_busy[f] = 1'b0;
                partial_top = soa_pkg::MaxSlabs;
                full_top = soa_pkg::MaxSlabs;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_request(soa_pkg::t_op op, int sl, int ob);
        t_outcome r;
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        i_valid <= 1'b1;
        i_operation <= op;
        i_slab_index <= 4'(sl);
        i_object_index <= 6'(ob);
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        r = allocator_step(op, sl, ob);
        pending_results.push_back(r);
        items_sent++;
        if (op == soa_pkg::OP_ALLOC && !r.status)
            live_objects.push_back('{int'(r.slab), int'(r.obj)});
        if (op == soa_pkg::OP_FREE_ALL) live_objects.delete();
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_results.size() > 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [0:0] idx, int value);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= 7'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == soa_pkg::CFG_OBJECTS_PER_SLAB) slots_cfg = value;
        else frames_cfg = value;
    endtask

    task automatic free_live();
        int k;
        t_handle h;
        k = $urandom_range(0, live_objects.size() - 1);
        h = live_objects[k];
        live_objects.delete(k);
        send_request(soa_pkg::OP_FREE, h.slab, h.obj);
    endtask

    task automatic test_directed();
        send_request(soa_pkg::OP_ALLOC, 0, 0);
        send_request(soa_pkg::OP_ALLOC, 15, 63);
        send_request(soa_pkg::OP_FREE, 0, 62);
        send_request(soa_pkg::OP_FREE, 0, 62);
        send_request(soa_pkg::OP_FREE, 9, 3);
        send_request(soa_pkg::OP_FREE, 0, 63);
        send_request(soa_pkg::OP_NONE, 15, 63);
        send_request(soa_pkg::OP_ALLOC, 0, 0);
        send_request(soa_pkg::OP_FREE_ALL, 15, 63);
        write_cfg(soa_pkg::CFG_OBJECTS_PER_SLAB, 0);
        write_cfg(soa_pkg::CFG_FRAMES_AVAILABLE, 1);
        repeat (9) send_request(soa_pkg::OP_ALLOC, 0, 0);
        send_request(soa_pkg::OP_FREE, 0, 12);
        send_request(soa_pkg::OP_FREE, 0, 5);
        while (live_objects.size() > 0) free_live();
    endtask

    task automatic test_frame_limits();
        write_cfg(soa_pkg::CFG_FRAMES_AVAILABLE, 0);
        send_request(soa_pkg::OP_ALLOC, 0, 0);
        write_cfg(soa_pkg::CFG_FRAMES_AVAILABLE, 31);
        write_cfg(soa_pkg::CFG_OBJECTS_PER_SLAB, 127);
        repeat (3) send_request(soa_pkg::OP_ALLOC, 0, 0);
        send_request(soa_pkg::OP_FREE_ALL, 0, 0);
    endtask

    task automatic test_random_phase(int slots, int frames, int count);
        int pick;
        write_cfg(soa_pkg::CFG_OBJECTS_PER_SLAB, slots);
        write_cfg(soa_pkg::CFG_FRAMES_AVAILABLE, frames);
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 55 || (pick < 90 && live_objects.size() == 0))
                send_request(soa_pkg::OP_ALLOC, $urandom_range(0, 15),
                             $urandom_range(0, 63));
            else if (pick < 90) free_live();
            else if (pick < 96)
                send_request(soa_pkg::OP_FREE, $urandom_range(0, 15),
                             $urandom_range(0, 63));
            else if (pick < 98) send_request(soa_pkg::OP_NONE, $urandom_range(0, 15),
                                             $urandom_range(0, 63));
            else send_request(soa_pkg::OP_FREE_ALL, $urandom_range(0, 15),
                              $urandom_range(0, 63));
        end
    endtask

    // result checker, receiver stall pattern and watchdog
    int stall_mode;
    int stall_len;
    always @(posedge i_clk) begin
        if (stall_len == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_len <= $urandom_range(4, 40);
        end else begin
            stall_len <= stall_len - 1;
        end
        i_stall <= (stall_mode == 0) ? 1'b0 :
                   (stall_mode == 1) ? ($urandom_range(0, 3) == 0) :
                                       ($urandom_range(0, 1) == 0);
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles > 20000) begin
                $display("status: fail");
                $finish;
            end
        end
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("result transfer with no request outstanding");
                errors++;
            end else begin
                t_outcome e;
                e = pending_results.pop_front();
                if (e.status) allocs_failed++;
                if (e.released) frames_released++;
                if (o_status !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, o_status);
                    errors++;
                end
                if (o_alloc_slab !== e.slab) begin
                    $error("alloc_slab: expected %0d, got %0d", e.slab, o_alloc_slab);
                    errors++;
                end
                if (o_alloc_object !== e.obj) begin
                    $error("alloc_object: expected %0d, got %0d", e.obj, o_alloc_object);
                    errors++;
                end
                if (o_slab_claimed !== e.claimed) begin
                    $error("slab_claimed: expected %0d, got %0d", e.claimed, o_slab_claimed);
                    errors++;
                end
                if (o_slab_released !== e.released) begin
                    $error("slab_released: expected %0d, got %0d", e.released,
                           o_slab_released);
                    errors++;
                end
            end
        end
    end

    initial begin
        slots_cfg = 64;
        frames_cfg = 16;
        partial_top = soa_pkg::MaxSlabs;
        full_top = soa_pkg::MaxSlabs;
        errors = 0;
        items_sent = 0;
        results_seen = 0;
        allocs_failed = 0;
        frames_released = 0;
        idle_cycles = 0;
        burst_left = 0;
        stall_mode = 0;
        stall_len = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_frame_limits();
        test_random_phase(8, 1, 200);
        test_random_phase(8, 3, 250);
        test_random_phase(64, 16, 300);
        test_random_phase(20, 16, 250);
        test_random_phase(127, 31, 250);
        test_random_phase(0, 2, 250);
        test_random_phase(33, 5, 300);
        drain();
        repeat (20) @(posedge i_clk);
        $display("covered %0d requests, %0d results, %0d failed allocations, %0d releases",
                 items_sent, results_seen, allocs_failed, frames_released);
        $display("slot counts 0 to 127 and frame limits 0 to 31, changed with slabs live");
        if (errors == 0 && pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire
